// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Transfer payloads, operation codes, character constants and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Character and attribute constants
	localparam logic [7:0] NEWLINE_CHAR       = 8'h0A;
	localparam logic [7:0] SPACE_CHAR         = 8'h20;
	localparam logic [7:0] DEFAULT_BLANK_ATTR = 8'h0F;

	// Output field types
	typedef logic [4:0] row_field_t;
	typedef logic [6:0] col_field_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} in_item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		row_field_t  cursor_row;
		col_field_t  cursor_col;
		logic        scrolled;
	} out_item_t;

	// Kind of pass over the screen memory
	typedef enum logic [1:0] {
		SW_INIT,
		SW_CLEAR,
		SW_SCROLL
	} sweep_kind_t;

	// Source of a result item
	typedef enum logic [1:0] {
		RES_PUT,
		RES_READ,
		RES_PLAIN,
		RES_SCROLL
	} res_sel_t;

	typedef struct packed {
		logic        put_go;
		logic        read_go;
		logic        sweep_start;
		sweep_kind_t sweep_kind;
		logic        sweep_run;
		logic        produce;
		res_sel_t    res_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic skid_full;
		logic scroll_need;
		logic sweep_last;
	} dp_stat_t;

endpackage

// ----- rtl/core/tcw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: operation sequencer of the text console writer
// Decodes each input transfer, starts reads and memory passes and tells
// the datapath when a result is ready.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  tcw_pkg::dp_stat_t    stat,
	output tcw_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   report_q;
	logic   scroll_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && !stat.skid_full;
	assign accept   = in_valid && in_ready;

	// Decode commands for the datapath
	always_comb begin
		cmd             = '0;
		cmd.sweep_kind  = tcw_pkg::SW_CLEAR;
		cmd.res_sel     = tcw_pkg::RES_PLAIN;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						tcw_pkg::OP_PUT: begin
							cmd.put_go = 1'b1;
							if (stat.scroll_need) begin
								cmd.sweep_start = 1'b1;
								cmd.sweep_kind  = tcw_pkg::SW_SCROLL;
							end else begin
								cmd.produce = 1'b1;
								cmd.res_sel = tcw_pkg::RES_PUT;
							end
						end
						tcw_pkg::OP_READ: begin
							cmd.read_go = 1'b1;
						end
						tcw_pkg::OP_CLEAR: begin
							cmd.sweep_start = 1'b1;
							cmd.sweep_kind  = tcw_pkg::SW_CLEAR;
						end
						default: begin
							cmd.produce = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.produce = 1'b1;
				cmd.res_sel = tcw_pkg::RES_READ;
			end
			ST_SWEEP: begin
				cmd.sweep_run = 1'b1;
			end
			ST_DRAIN: begin
				cmd.produce = report_q;
				cmd.res_sel = scroll_q ? tcw_pkg::RES_SCROLL : tcw_pkg::RES_PLAIN;
			end
			default: begin
				cmd.produce = 1'b0;
			end
		endcase
	end

	// Hold state; reset starts the power-up clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			report_q <= 1'b0;
			scroll_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							tcw_pkg::OP_PUT: begin
								if (stat.scroll_need) begin
									state_q  <= ST_SWEEP;
									report_q <= 1'b1;
									scroll_q <= 1'b1;
								end
							end
							tcw_pkg::OP_READ: begin
								state_q <= ST_READ;
							end
							tcw_pkg::OP_CLEAR: begin
								state_q  <= ST_SWEEP;
								report_q <= 1'b1;
								scroll_q <= 1'b0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (stat.sweep_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/tcw_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_dp: datapath of the text console writer
// Cursor, blank attribute, screen memory with its sweep address
// generator, and the output register with a skid stage.
// ----------------------------------------------------------------------------
module tcw_dp #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcw_pkg::ctrl_cmd_t   cmd,
	output tcw_pkg::dp_stat_t    stat,
	input  tcw_pkg::in_item_t    in_data,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tcw_pkg::out_item_t   out_data
);

	localparam int CELLS      = ROWS * COLUMNS;
	localparam int COPY_CELLS = CELLS - COLUMNS;
	localparam int AW         = $clog2(CELLS);
	localparam int RW         = $clog2(ROWS);
	localparam int CW         = $clog2(COLUMNS);

	logic [7:0]            blank_q;
	logic [RW-1:0]         row_q;
	logic [RW-1:0]         row_nxt;
	logic [CW-1:0]         col_q;
	logic [CW-1:0]         col_nxt;
	logic                  is_newline;
	logic                  wrap;
	logic                  scroll_need;
	logic                  put_write;
	logic [AW-1:0]         cur_addr;
	logic                  req_ok;
	logic [AW-1:0]         req_addr;
	logic                  rd_ok_s1;
	logic [AW-1:0]         cnt_q;
	tcw_pkg::sweep_kind_t  mode_q;
	logic                  copy_now;
	logic [AW-1:0]         sweep_raddr;
	logic                  wr_vld_s1;
	logic                  copy_s1;
	logic [AW-1:0]         wr_addr_s1;
	logic [15:0]           blank_cell;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [15:0]           ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [15:0]           ram_rdata;
	tcw_pkg::out_item_t    res;
	tcw_pkg::out_item_t    out_q;
	tcw_pkg::out_item_t    skid_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;
	logic                  out_free;

	// Advance the cursor for a put
	assign is_newline  = (in_data.char_code == tcw_pkg::NEWLINE_CHAR);
	assign wrap        = is_newline || (col_q == CW'(COLUMNS - 1));
	assign scroll_need = wrap && (row_q == RW'(ROWS - 1));
	assign col_nxt     = wrap ? '0 : col_q + CW'(1);
	assign row_nxt     = scroll_need ? RW'(ROWS - 1) : (wrap ? row_q + RW'(1) : row_q);
	assign put_write   = cmd.put_go && !is_newline;

	// Form cell addresses
	assign cur_addr = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign req_ok   = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLUMNS);
	assign req_addr = req_ok ? AW'(32'(in_data.read_row) * COLUMNS + 32'(in_data.read_col))
	                         : '0;

	// Generate sweep read address; a scroll copies each row from the one below
	assign copy_now    = (mode_q == tcw_pkg::SW_SCROLL) && (32'(cnt_q) < COPY_CELLS);
	assign sweep_raddr = copy_now ? AW'(32'(cnt_q) + COLUMNS) : '0;
	assign blank_cell  = {(mode_q == tcw_pkg::SW_INIT) ? tcw_pkg::DEFAULT_BLANK_ATTR : blank_q,
	                      tcw_pkg::SPACE_CHAR};

	// Select memory ports
	assign ram_we    = wr_vld_s1 || put_write;
	assign ram_waddr = wr_vld_s1 ? wr_addr_s1 : cur_addr;
	assign ram_wdata = wr_vld_s1 ? (copy_s1 ? ram_rdata : blank_cell)
	                             : {in_data.attribute, in_data.char_code};
	assign ram_raddr = cmd.read_go ? req_addr : sweep_raddr;

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Hold cursor, blank attribute and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			blank_q   <= tcw_pkg::DEFAULT_BLANK_ATTR;
			cnt_q     <= '0;
			mode_q    <= tcw_pkg::SW_INIT;
			wr_vld_s1 <= 1'b0;
		end else begin
			if (cmd.put_go) begin
				row_q <= row_nxt;
				col_q <= col_nxt;
			end
			if (cfg_we) begin
				blank_q <= cfg_wdata;
			end
			if (cmd.sweep_start) begin
				cnt_q  <= '0;
				mode_q <= cmd.sweep_kind;
			end else if (cmd.sweep_run) begin
				cnt_q <= cnt_q + AW'(1);
			end
			wr_vld_s1 <= cmd.sweep_run;
		end
	end

	// Stage the sweep write and the read range check
	always_ff @(posedge clk) begin
		wr_addr_s1 <= cnt_q;
		copy_s1    <= copy_now;
		rd_ok_s1   <= req_ok;
	end

	// Build the result item
	always_comb begin
		res.cell_value = '0;
		res.cursor_row = tcw_pkg::row_field_t'(row_q);
		res.cursor_col = tcw_pkg::col_field_t'(col_q);
		res.scrolled   = 1'b0;
		unique case (cmd.res_sel)
			tcw_pkg::RES_PUT: begin
				res.cursor_row = tcw_pkg::row_field_t'(row_nxt);
				res.cursor_col = tcw_pkg::col_field_t'(col_nxt);
			end
			tcw_pkg::RES_READ: begin
				res.cell_value = rd_ok_s1 ? ram_rdata : '0;
			end
			tcw_pkg::RES_SCROLL: begin
				res.scrolled = 1'b1;
			end
			default: begin
				res.scrolled = 1'b0;
			end
		endcase
	end

	// Output register with skid stage
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= cmd.produce;
			end else begin
				out_valid_q <= cmd.produce;
			end
		end else if (cmd.produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (cmd.produce) begin
					skid_q <= res;
				end
			end else if (cmd.produce) begin
				out_q <= res;
			end
		end else if (cmd.produce) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.skid_full   = skid_valid_q;
	assign stat.scroll_need = scroll_need;
	assign stat.sweep_last  = (cnt_q == AW'(CELLS - 1));

`ifndef ASSERT_OFF
	// A character write never lands on a sweep write
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(put_write && wr_vld_s1))
		else $error("put write collides with sweep write");

	// A result never arrives while the skid stage is occupied
	a_skid_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.produce |-> !skid_valid_q)
		else $error("result produced with skid stage full");

	// The cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= RW'(ROWS - 1)) && (col_q <= CW'(COLUMNS - 1)))
		else $error("cursor off screen");

	// A cell read never shares the read port with a sweep
	a_read_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.read_go && cmd.sweep_run))
		else $error("cell read during sweep");
`endif

endmodule

// ----- rtl/core/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Put, read and clear on a ROWS x COLUMNS screen of attribute/character cells.
// ----------------------------------------------------------------------------
// Put without scroll: result registered in the output register, or in the
// skid stage while the output stalls; new items wait while the skid is full.
// Read: cell from the registered read of the screen RAM, produced in ST_READ.
// Clear and scroll: one cell per cycle via the single screen RAM write port.
// Reset: cursor to 0,0, blank attribute 0x0F; a clearing pass fills the screen
// with blanks, and no item is accepted until it ends.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcw_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tcw_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);

	tcw_pkg::ctrl_cmd_t cmd;
	tcw_pkg::dp_stat_t  stat;

	// Sequence operations
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (in_data.operation),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold cursor, screen and results
	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
